[hw/rtl/prrts_pkg.sv]
// Shared types, codes and helpers for the priority round-robin task scheduler.
// Used by prrts_cell and priority_round_robin_task_scheduler_top; depends on nothing.
`timescale 1ns / 1ps

package prrts_pkg;

   localparam int TASK_SLOTS_DEF      = 16;
   localparam int PRIORITY_LEVELS_DEF = 16;
   localparam int CSR_IDX_W           = 1;
   localparam int CSR_DATA_W          = 32;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SCHED = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      TS_INVALID = 3'd0,
      TS_UNRUN   = 3'd1,
      TS_READY   = 3'd2,
      TS_DELAYED = 3'd3,
      TS_MUTEX   = 3'd4,
      TS_SEMA    = 3'd5,
      TS_KILLED  = 3'd6,
      TS_UNKNOWN = 3'd7
   } status_type;

   typedef enum logic {
      CSR_PRIORITY_MODE = 1'b0,
      CSR_PREEMPT       = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SCH_IDLE  = 2'd0,
      SCH_LEVEL = 2'd1,
      SCH_PICK  = 2'd2,
      SCH_DONE  = 2'd3
   } sch_state_type;

   // One task entry as held in a cell
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  level;
      logic [31:0] sleep;
   } entry_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic shift;
      logic load;
      logic mark;
   } cell_ctl_type;

   function automatic logic is_runnable(input logic [2:0] st);
      return (st == TS_UNRUN) || (st == TS_READY);
   endfunction

   // Count a delayed entry down by one tick; wake it at zero
   function automatic entry_type tick_update(input entry_type e, input logic en);
      entry_type r;
      r = e;
      if (en && e.status == TS_DELAYED) begin
         r.sleep = e.sleep - 32'd1;
         if (r.sleep == 32'd0) begin
            r.status = TS_READY;
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/prrts_cell.sv]
// One task-entry cell of the scheduler ring: holds status, level and sleep count.
// Depends on prrts_pkg for the entry and control types.
`timescale 1ns / 1ps

module prrts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  prrts_pkg::cell_ctl_type ctl,
   input  prrts_pkg::entry_type   shift_in,
   input  prrts_pkg::entry_type   load_data,
   output prrts_pkg::entry_type   q
);

   logic [2:0]  status_ff, status_in;
   logic [3:0]  level_ff, level_in;
   logic [31:0] sleep_ff, sleep_in;

   // Pick the next entry: direct load, ready mark, or hand-off from neighbor
   always_comb begin
      status_in = status_ff;
      level_in  = level_ff;
      sleep_in  = sleep_ff;
      if (ctl.load) begin
         status_in = load_data.status;
         level_in  = load_data.level;
         sleep_in  = load_data.sleep;
      end else if (ctl.mark) begin
         status_in = prrts_pkg::TS_READY;
      end else if (ctl.shift) begin
         status_in = shift_in.status;
         level_in  = shift_in.level;
         sleep_in  = shift_in.sleep;
      end
   end

   // Status resets to invalid; level and sleep are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= prrts_pkg::TS_INVALID;
      end else begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      sleep_ff <= sleep_in;
   end

   assign q.status = status_ff;
   assign q.level  = level_ff;
   assign q.sleep  = sleep_ff;

endmodule

[hw/rtl/priority_round_robin_task_scheduler_top.sv]
// Top level of the priority round-robin task scheduler: sequencer and cell ring.
// Depends on prrts_pkg and prrts_cell.
`timescale 1ns / 1ps

// Usage
// A command is taken at a clock edge with start high and busy low. Every
// command gives one result, shown for one cycle with rsp_valid high; the
// receiver cannot stall it. Task entries sit in a ring of TASK_SLOTS cells.
// A scan rotates the ring by one cell per cycle and evaluates the head cell;
// a full pass leaves the ring in place. A write or unused action answers
// from the idle state. A tick without preemption, or a scan that finds
// nothing runnable, answers after the first pass; otherwise a pick pass
// and a done step follow. The first pass counts sleepers down on a tick
// and finds the most urgent level; the second finds the rotated pick.
// busy stays high until the result shows.
// The csr channel is always ready; write it only while the block is idle.
// Reset invalidates all entries, restores both mode bits to 1, clears the
// tick counter and per-level picks; no clearing pass is needed.

module priority_round_robin_task_scheduler_top #(
   parameter int TASK_SLOTS      = prrts_pkg::TASK_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = prrts_pkg::PRIORITY_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [3:0]                      req_task_index,
   input  logic [2:0]                      req_entry_state,
   input  logic [3:0]                      req_entry_priority,
   input  logic [31:0]                     req_entry_sleep_ticks,
   output logic                            rsp_valid,
   output logic [3:0]                      rsp_chosen_task,
   output logic                            rsp_chosen_valid,
   output logic                            rsp_first_run,
   output logic [4:0]                      rsp_woken_count,
   output logic [31:0]                     rsp_tick_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prrts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prrts_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int WW = $clog2(TASK_SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

   // Clamp a stored level to the least urgent one
   function automatic logic [LW-1:0] clamp_level(input logic [3:0] l);
      if (int'(l) >= PRIORITY_LEVELS) begin
         return LW'(PRIORITY_LEVELS - 1);
      end
      return LW'(l);
   endfunction

   prrts_pkg::sch_state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          wake_ff, wake_in;
   logic          sched_ff, sched_in;
   logic [WW-1:0] woken_ff, woken_in;
   logic          any_ff, any_in;
   logic [LW-1:0] best_ff, best_in;
   logic [IW-1:0] start_ff, start_in;
   logic          hita_ff, hita_in, hitb_ff, hitb_in;
   logic [IW-1:0] picka_ff, picka_in, pickb_ff, pickb_in;
   logic [LW-1:0] lvla_ff, lvla_in, lvlb_ff, lvlb_in;
   logic          unruna_ff, unruna_in, unrunb_ff, unrunb_in;
   logic [IW-1:0] rotate_ff, rotate_in;
   logic [31:0]   tick_ff, tick_in;
   logic          mode_ff, preempt_ff;
   logic [IW-1:0] last_pick_ff [PRIORITY_LEVELS];
   logic          lp_we;
   logic [LW-1:0] lp_idx;
   logic [IW-1:0] lp_data;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_task_ff, rsp_task_in;
   logic          rsp_cv_ff, rsp_cv_in;
   logic          rsp_fr_ff, rsp_fr_in;
   logic [4:0]    rsp_woken_ff, rsp_woken_in;
   logic [31:0]   rsp_tick_ff, rsp_tick_in;

   logic          accept;
   logic          wr_en;
   logic          shift;
   logic          mark_en;
   logic [IW-1:0] mark_idx;
   logic          tick_en;
   prrts_pkg::entry_type q [TASK_SLOTS];
   prrts_pkg::entry_type wr_data;
   prrts_pkg::entry_type head_w;
   logic          head_run;
   logic          head_wake;
   logic [LW-1:0] head_lvl;
   logic          head_match;

   assign accept    = start && !busy;
   assign busy      = (state_ff != prrts_pkg::SCH_IDLE);
   assign csr_ready = 1'b1;

   // Head cell seen through the tick countdown
   assign tick_en   = wake_ff && (state_ff == prrts_pkg::SCH_LEVEL);
   assign head_w    = prrts_pkg::tick_update(q[0], tick_en);
   assign head_wake = tick_en && (q[0].status == prrts_pkg::TS_DELAYED) &&
                      (q[0].sleep == 32'd1);
   assign head_run  = prrts_pkg::is_runnable(head_w.status);
   assign head_lvl  = clamp_level(head_w.level);
   assign head_match = head_run && (!mode_ff || head_lvl == best_ff);

   assign wr_data.status = req_entry_state;
   assign wr_data.level  = req_entry_priority;
   assign wr_data.sleep  = req_entry_sleep_ticks;

   // Cell ring: each cell takes its right neighbor, the last takes the head
   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      prrts_pkg::cell_ctl_type ctl;
      prrts_pkg::entry_type    nb;
      assign ctl.shift = shift;
      assign ctl.load  = wr_en && (int'(req_task_index) == i);
      assign ctl.mark  = mark_en && (int'(mark_idx) == i);
      if (i == TASK_SLOTS - 1) begin : g_wrap
         assign nb = head_w;
      end else begin : g_next
         assign nb = q[i+1];
      end
      prrts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .shift_in  (nb),
         .load_data (wr_data),
         .q         (q[i])
      );
   end

   // Sequencer: next state, scan bookkeeping and result
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wake_in      = wake_ff;
      sched_in     = sched_ff;
      woken_in     = woken_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      start_in     = start_ff;
      hita_in      = hita_ff;
      hitb_in      = hitb_ff;
      picka_in     = picka_ff;
      pickb_in     = pickb_ff;
      lvla_in      = lvla_ff;
      lvlb_in      = lvlb_ff;
      unruna_in    = unruna_ff;
      unrunb_in    = unrunb_ff;
      rotate_in    = rotate_ff;
      tick_in      = tick_ff;
      rsp_valid_in = 1'b0;
      rsp_task_in  = 4'd0;
      rsp_cv_in    = 1'b0;
      rsp_fr_in    = 1'b0;
      rsp_woken_in = 5'd0;
      rsp_tick_in  = tick_ff;
      wr_en        = 1'b0;
      shift        = 1'b0;
      mark_en      = 1'b0;
      mark_idx     = picka_ff;
      lp_we        = 1'b0;
      lp_idx       = lvla_ff;
      lp_data      = picka_ff;

      case (state_ff)
         prrts_pkg::SCH_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               woken_in = '0;
               any_in   = 1'b0;
               best_in  = LW'(PRIORITY_LEVELS - 1);
               case (req_action)
                  prrts_pkg::ACT_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     wake_in  = 1'b1;
                     sched_in = preempt_ff;
                     state_in = prrts_pkg::SCH_LEVEL;
                  end
                  prrts_pkg::ACT_SCHED: begin
                     wake_in  = 1'b0;
                     sched_in = 1'b1;
                     state_in = prrts_pkg::SCH_LEVEL;
                  end
                  prrts_pkg::ACT_WRITE: begin
                     wr_en        = (int'(req_task_index) < TASK_SLOTS);
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         prrts_pkg::SCH_LEVEL: begin
            shift    = 1'b1;
            woken_in = woken_ff + WW'(head_wake);
            if (head_run && (!any_ff || head_lvl < best_ff)) begin
               best_in = head_lvl;
               any_in  = 1'b1;
            end
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               if (sched_ff && any_in) begin
                  start_in = mode_ff ? last_pick_ff[best_in] : rotate_ff;
                  hita_in  = 1'b0;
                  hitb_in  = 1'b0;
                  state_in = prrts_pkg::SCH_PICK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_woken_in = 5'(woken_in);
                  state_in     = prrts_pkg::SCH_IDLE;
               end
            end
         end

         prrts_pkg::SCH_PICK: begin
            shift = 1'b1;
            // First match past the start, and first match overall as the wrap
            if (head_match && cnt_ff > start_ff && !hita_ff) begin
               hita_in   = 1'b1;
               picka_in  = cnt_ff;
               lvla_in   = head_lvl;
               unruna_in = (head_w.status == prrts_pkg::TS_UNRUN);
            end
            if (head_match && !hitb_ff) begin
               hitb_in   = 1'b1;
               pickb_in  = cnt_ff;
               lvlb_in   = head_lvl;
               unrunb_in = (head_w.status == prrts_pkg::TS_UNRUN);
            end
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = prrts_pkg::SCH_DONE;
            end
         end

         prrts_pkg::SCH_DONE: begin
            mark_idx     = hita_ff ? picka_ff : pickb_ff;
            mark_en      = hita_ff ? unruna_ff : unrunb_ff;
            lp_we        = 1'b1;
            lp_idx       = hita_ff ? lvla_ff : lvlb_ff;
            lp_data      = mark_idx;
            rotate_in    = mark_idx;
            rsp_valid_in = 1'b1;
            rsp_task_in  = 4'(mark_idx);
            rsp_cv_in    = 1'b1;
            rsp_fr_in    = mark_en;
            rsp_woken_in = 5'(woken_ff);
            state_in     = prrts_pkg::SCH_IDLE;
         end

         default: begin
            state_in = prrts_pkg::SCH_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prrts_pkg::SCH_IDLE;
         cnt_ff       <= '0;
         rotate_ff    <= LAST_IDX;
         tick_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rotate_ff    <= rotate_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan bookkeeping and result payload
   always_ff @(posedge clock) begin
      wake_ff      <= wake_in;
      sched_ff     <= sched_in;
      woken_ff     <= woken_in;
      any_ff       <= any_in;
      best_ff      <= best_in;
      start_ff     <= start_in;
      hita_ff      <= hita_in;
      hitb_ff      <= hitb_in;
      picka_ff     <= picka_in;
      pickb_ff     <= pickb_in;
      lvla_ff      <= lvla_in;
      lvlb_ff      <= lvlb_in;
      unruna_ff    <= unruna_in;
      unrunb_ff    <= unrunb_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_cv_ff    <= rsp_cv_in;
      rsp_fr_ff    <= rsp_fr_in;
      rsp_woken_ff <= rsp_woken_in;
      rsp_tick_ff  <= rsp_tick_in;
   end

   // Last pick per level, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            last_pick_ff[l] <= '0;
         end
      end else if (lp_we) begin
         last_pick_ff[lp_idx] <= lp_data;
      end
   end

   // Mode registers on the csr transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b1;
         preempt_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == prrts_pkg::CSR_PRIORITY_MODE) begin
            mode_ff <= csr_wdata[0];
         end
         if (csr_index == prrts_pkg::CSR_PREEMPT) begin
            preempt_ff <= csr_wdata[0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_task  = rsp_task_ff;
   assign rsp_chosen_valid = rsp_cv_ff;
   assign rsp_first_run    = rsp_fr_ff;
   assign rsp_woken_count  = rsp_woken_ff;
   assign rsp_tick_total   = rsp_tick_ff;

   // An accepted command either starts a scan or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted command made no progress");

   // A first-run flag only comes with a decision
   a_first_run_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_run) |-> rsp_chosen_valid)
      else $error("first_run without a chosen task");

   // A decision follows the final step of a pick scan
   a_decision_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chosen_valid) |-> $past(state_ff == prrts_pkg::SCH_DONE))
      else $error("decision outside the done step");

   // The ring is never written directly while it rotates
   a_no_load_in_scan: assert property (@(posedge clock) disable iff (reset)
      shift |-> (!wr_en && !mark_en))
      else $error("direct cell update during a scan");

endmodule

[dv/priority_round_robin_task_scheduler_top_tb.sv]
// Testbench for the priority round-robin task scheduler: a directed table, then
// random command streams under several mode settings, checked against a predictor.
// Depends on prrts_pkg and priority_round_robin_task_scheduler_top.
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_top_tb;

   localparam int NSLOT      = 16;
   localparam int NLVL       = 16;
   localparam int SETTLE     = 2 * NSLOT + 8;
   localparam int CYCLE_CAP  = 600000;
   localparam int PHASE_CMDS = 110;

   typedef struct {
      prrts_pkg::action_type act;
      logic [3:0]  idx;
      logic [2:0]  st;
      logic [3:0]  prio;
      logic [31:0] slp;
   } cmd_type;

   typedef struct {
      logic [3:0]  task_id;
      logic        found;
      logic        fresh;
      logic [4:0]  woken;
      logic [31:0] ticks;
   } decision_type;

   typedef struct {
      cmd_type      c;
      bit           typed;
      decision_type want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [3:0]  req_task_index;
   logic [2:0]  req_entry_state;
   logic [3:0]  req_entry_priority;
   logic [31:0] req_entry_sleep_ticks;
   logic        rsp_valid;
   logic [3:0]  rsp_chosen_task;
   logic        rsp_chosen_valid;
   logic        rsp_first_run;
   logic [4:0]  rsp_woken_count;
   logic [31:0] rsp_tick_total;
   logic        csr_valid;
   logic        csr_ready;
   logic [prrts_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [prrts_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the scheduler state
   prrts_pkg::status_type task_st[NSLOT];
   logic [3:0]  task_lvl[NSLOT];
   logic [31:0] task_sleep[NSLOT];
   logic [3:0]  lvl_last[NLVL];
   logic [3:0]  rr_ptr;
   logic [31:0] tick_cnt;
   int          sleeper_cnt;
   bit          prio_mode;
   bit          tick_preempt;

   decision_type pending_decisions[$];
   int           mismatches;
   int           cycles;
   bit           quiet;

   priority_round_robin_task_scheduler_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_task_index(req_task_index),
      .req_entry_state(req_entry_state), .req_entry_priority(req_entry_priority),
      .req_entry_sleep_ticks(req_entry_sleep_ticks),
      .rsp_valid(rsp_valid), .rsp_chosen_task(rsp_chosen_task),
      .rsp_chosen_valid(rsp_chosen_valid), .rsp_first_run(rsp_first_run),
      .rsp_woken_count(rsp_woken_count), .rsp_tick_total(rsp_tick_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit can_run(int t);
      return task_st[t] == prrts_pkg::TS_UNRUN || task_st[t] == prrts_pkg::TS_READY;
   endfunction

   function automatic int eff_level(int t);
      return (task_lvl[t] < NLVL) ? int'(task_lvl[t]) : NLVL - 1;
   endfunction

   // Find the next task: plain rotation, or rotation within the most urgent level
   function automatic bit find_next(output int pick);
      int  best;
      int  t;
      bit  any;
      best = NLVL - 1;
      any  = 1'b0;
      pick = 0;
      if (!prio_mode) begin
         for (int k = 1; k <= NSLOT; k++) begin
            t = (int'(rr_ptr) + k) % NSLOT;
            if (can_run(t)) begin
               pick = t;
               return 1'b1;
            end
         end
         return 1'b0;
      end
      for (int i = 0; i < NSLOT; i++) begin
         if (can_run(i) && (!any || eff_level(i) < best)) begin
            best = eff_level(i);
            any  = 1'b1;
         end
      end
      if (!any) return 1'b0;
      for (int k = 1; k <= NSLOT; k++) begin
         t = (int'(lvl_last[best]) + k) % NSLOT;
         if (can_run(t) && eff_level(t) == best) begin
            pick = t;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void decide(inout decision_type d);
      int p;
      if (!find_next(p)) return;
      rr_ptr = p[3:0];
      lvl_last[eff_level(p)] = p[3:0];
      d.task_id = p[3:0];
      d.found   = 1'b1;
      if (task_st[p] == prrts_pkg::TS_UNRUN) begin
         task_st[p] = prrts_pkg::TS_READY;
         d.fresh    = 1'b1;
      end
   endfunction

   // Advance the shadow state by one command and return the decision it gives
   function automatic decision_type apply_cmd(cmd_type c);
      decision_type d;
      int           woke;
      d    = '{default: '0};
      woke = 0;
      case (c.act)
         prrts_pkg::ACT_TICK: begin
            tick_cnt++;
            if (sleeper_cnt > 0) begin
               for (int t = 0; t < NSLOT; t++) begin
                  if (task_st[t] == prrts_pkg::TS_DELAYED) begin
                     task_sleep[t]--;
                     if (task_sleep[t] == 32'd0) begin
                        task_st[t] = prrts_pkg::TS_READY;
                        woke++;
                     end
                  end
               end
               sleeper_cnt = (woke <= sleeper_cnt) ? sleeper_cnt - woke : 0;
            end
            d.woken = woke[4:0];
            if (tick_preempt) decide(d);
         end
         prrts_pkg::ACT_SCHED: decide(d);
         prrts_pkg::ACT_WRITE: begin
            if (task_st[c.idx] == prrts_pkg::TS_DELAYED && sleeper_cnt > 0) sleeper_cnt--;
            task_st[c.idx]    = prrts_pkg::status_type'(c.st);
            task_lvl[c.idx]   = c.prio;
            task_sleep[c.idx] = c.slp;
            if (task_st[c.idx] == prrts_pkg::TS_DELAYED) sleeper_cnt++;
         end
         default: ;
      endcase
      d.ticks = tick_cnt;
      return d;
   endfunction

   // Compare each strobed result with the oldest pending decision
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            decision_type w;
            w = pending_decisions.pop_front();
            if (rsp_chosen_task !== w.task_id || rsp_chosen_valid !== w.found ||
                rsp_first_run !== w.fresh || rsp_woken_count !== w.woken ||
                rsp_tick_total !== w.ticks) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch cycle %0d: exp task %0d v %0b fr %0b wk %0d tk %0d,",
                            " got task %0d v %0b fr %0b wk %0d tk %0d"},
                           cycles, w.task_id, w.found, w.fresh, w.woken, w.ticks,
                           rsp_chosen_task, rsp_chosen_valid, rsp_first_run,
                           rsp_woken_count, rsp_tick_total);
            end
         end
      end
   end

   // Hard stop on a hang
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one command; keep start high across back-to-back transfers
   task automatic send_cmd(cmd_type c, bit typed, decision_type want);
      int           gap;
      decision_type got;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_action            <= c.act;
      req_task_index        <= c.idx;
      req_entry_state       <= c.st;
      req_entry_priority    <= c.prio;
      req_entry_sleep_ticks <= c.slp;
      do @(posedge clock); while (busy);
      got = apply_cmd(c);
      pending_decisions.push_back(typed ? want : got);
   endtask

   // Wait until every pending result has come and the block is quiet
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_decisions.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(prrts_pkg::csr_idx_type idx, bit val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= {31'($urandom_range(0, 32'h7fff_ffff)), val};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == prrts_pkg::CSR_PRIORITY_MODE) prio_mode = val;
      else tick_preempt = val;
   endtask

   function automatic cmd_type random_cmd();
      cmd_type c;
      int      r;
      c.idx  = 4'($urandom_range(0, 15));
      c.prio = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      if (r < 3) c.st = prrts_pkg::TS_UNRUN;
      else if (r < 5) c.st = prrts_pkg::TS_READY;
      else if (r < 7) c.st = prrts_pkg::TS_DELAYED;
      else c.st = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 9);
      if (r < 8) c.slp = $urandom_range(1, 6);
      else if (r < 9) c.slp = 32'd0;
      else c.slp = $urandom;
      r = $urandom_range(0, 99);
      if (r < 38) c.act = prrts_pkg::ACT_WRITE;
      else if (r < 70) c.act = prrts_pkg::ACT_TICK;
      else if (r < 95) c.act = prrts_pkg::ACT_SCHED;
      else c.act = prrts_pkg::ACT_NONE;
      return c;
   endfunction

   row_type      rows[$];
   decision_type blank;

   function automatic row_type mk(prrts_pkg::action_type a, int i,
                                  prrts_pkg::status_type s, int p,
                                  logic [31:0] sl, bit typed, int tk);
      row_type r;
      r.c     = '{act: a, idx: 4'(i), st: s, prio: 4'(p), slp: sl};
      r.typed = typed;
      r.want  = '{task_id: 4'd0, found: 1'b0, fresh: 1'b0, woken: 5'd0, ticks: tk};
      return r;
   endfunction

   initial begin
      bit modes[5][2];
      start = 1'b0; reset = 1'b1; csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      req_action = prrts_pkg::ACT_NONE; req_task_index = '0; req_entry_state = '0;
      req_entry_priority = '0; req_entry_sleep_ticks = '0;
      mismatches = 0; cycles = 0; quiet = 1'b0;
      blank = '{default: '0};
      for (int i = 0; i < NSLOT; i++) begin
         task_st[i] = prrts_pkg::TS_INVALID; task_lvl[i] = '0; task_sleep[i] = '0;
      end
      for (int i = 0; i < NLVL; i++) lvl_last[i] = '0;
      rr_ptr = 4'(NSLOT - 1); tick_cnt = '0; sleeper_cnt = 0;
      prio_mode = 1'b1; tick_preempt = 1'b1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty table, extremes, every status, wake-ups, rotation
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 1, 0));
      rows.push_back(mk(prrts_pkg::ACT_TICK, 0, prrts_pkg::TS_INVALID, 0, 0, 1, 1));
      rows.push_back(mk(prrts_pkg::ACT_NONE, 15, prrts_pkg::TS_UNKNOWN, 15, '1, 1, 1));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 15, prrts_pkg::TS_UNRUN, 15, '1, 1, 1));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 0, prrts_pkg::TS_UNRUN, 0, 32'hFFFF_FFFF, 1, 1));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 3, prrts_pkg::TS_DELAYED, 0, 1, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_TICK, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 5, prrts_pkg::TS_DELAYED, 4, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 7, prrts_pkg::TS_UNKNOWN, 8, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 8, prrts_pkg::TS_MUTEX, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 9, prrts_pkg::TS_SEMA, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 10, prrts_pkg::TS_KILLED, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 11, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 0, prrts_pkg::TS_READY, 15, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_WRITE, 5, prrts_pkg::TS_DELAYED, 0, 2, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_TICK, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_TICK, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      rows.push_back(mk(prrts_pkg::ACT_SCHED, 0, prrts_pkg::TS_INVALID, 0, 0, 0, 0));
      foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].want);
      drain();

      // Random phases over the mode settings, extremes included
      modes = '{'{0, 1}, '{1, 0}, '{0, 0}, '{1, 1}, '{0, 1}};
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(prrts_pkg::CSR_PRIORITY_MODE, modes[ph][0]);
         write_csr(prrts_pkg::CSR_PREEMPT, modes[ph][1]);
         for (int n = 0; n < PHASE_CMDS; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            // hold off until everything in flight has come back
            if (n == PHASE_CMDS / 2) drain();
            send_cmd(random_cmd(), 1'b0, blank);
         end
         drain();
         repeat (SETTLE) @(posedge clock);
      end

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_decisions.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
